@@ rtl/tcw_pkg.sv @@
// shared types, field widths and codes of the text console writer
`default_nettype none

package tcw_pkg;

    // default geometry and queue size
    localparam int COLUMNS_DEF     = 80;
    localparam int ROWS_DEF        = 25;
    localparam int QUEUE_DEPTH_DEF = 2;

    // port field widths
    localparam int KIND_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int ROW_OUT_W   = 5;
    localparam int COL_OUT_W   = 7;
    localparam int COLOR_W     = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CELL_W      = 2 * CHAR_W;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FG = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BG = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;

    // classified operations
    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] code;
        logic [INDEX_W-1:0] index;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/tcw_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/tcw_front.sv @@
// input side: takes items and classifies them into commands
`default_nettype none

module tcw_front #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [tcw_pkg::KIND_W-1:0]  kind,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0] cell_index,
    output logic                             push_valid,
    input  wire logic                        push_ready,
    output tcw_pkg::cmd_t                    push_cmd
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;

    logic index_ok;

    assign index_ok   = (32'(cell_index) < 32'(CELLS));
    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    always_comb
    begin
        push_cmd.code  = char_code;
        push_cmd.index = cell_index;
        unique case (kind)
            KIND_PUT:   push_cmd.op = (char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
            KIND_CLEAR: push_cmd.op = OP_CLEAR;
            // out-of-range read answers like an ignored item
            KIND_READ:  push_cmd.op = index_ok ? OP_READ : OP_NOP;
            default:    push_cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/tcw_queue.sv @@
// small command fifo between the front and back parts
`default_nettype none

module tcw_queue #(
    parameter int DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire tcw_pkg::cmd_t push_cmd,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output tcw_pkg::cmd_t      pop_cmd
);
    import tcw_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_fire, pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push_fire) - CNT_W'(pop_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tcw_back.sv @@
// execution side: cursor, screen store sequencing and result register
`default_nettype none

module tcw_back #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [tcw_pkg::CHAR_W-1:0]    attr,
    input  wire logic                          pop_valid,
    output logic                               pop_ready,
    input  wire tcw_pkg::cmd_t                 pop_cmd,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [tcw_pkg::CHAR_W-1:0]    read_char,
    output logic      [tcw_pkg::CHAR_W-1:0]    read_attr,
    output logic      [tcw_pkg::ROW_OUT_W-1:0] cursor_row,
    output logic      [tcw_pkg::COL_OUT_W-1:0] cursor_col,
    output logic                               scrolled
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS + 1);

    localparam logic [ADDR_W-1:0] COLS_A        = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_COPY     = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
    localparam logic [ROW_W-1:0]  BOTTOM_ROW    = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_FULL      = COL_W'(COLUMNS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_COPY  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_FILL  = 6'b010000,
        S_WRITE = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic                wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]   wr_addr_reg, wr_addr_next;
    logic                scroll_reg, scroll_next;
    logic                pend_char_reg, pend_char_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   read_char_reg;
    logic [CHAR_W-1:0]   read_attr_reg;
    logic [ROW_OUT_W-1:0] cursor_row_reg;
    logic [COL_OUT_W-1:0] cursor_col_reg;
    logic                scrolled_reg;

    logic                can_issue;
    logic                wrap;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;
    logic                res_fire;
    logic [CHAR_W-1:0]   res_char;
    logic [CHAR_W-1:0]   res_attr;
    logic                res_scrolled;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign can_issue = !out_valid_reg || out_ready;
    assign wrap      = (pop_cmd.op == OP_NEWLINE) || (col_reg == COL_FULL);

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        ptr_next       = ptr_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        scroll_next    = scroll_reg;
        pend_char_next = pend_char_reg;
        char_next      = char_reg;
        pop_ready      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = wr_addr_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = ptr_reg + COLS_A;
        res_fire       = 1'b0;
        res_char       = '0;
        res_attr       = '0;
        res_scrolled   = scroll_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                res_scrolled = 1'b0;
                if (pop_valid && can_issue)
                begin
                    pop_ready      = 1'b1;
                    scroll_next    = 1'b0;
                    pend_char_next = 1'b0;
                    char_next      = pop_cmd.code;
                    unique case (pop_cmd.op)
                        OP_READ:
                        begin
                            ram_raddr  = ADDR_W'(pop_cmd.index);
                            state_next = S_READ;
                        end
                        OP_CLEAR:
                        begin
                            ptr_next   = '0;
                            state_next = S_FILL;
                        end
                        OP_PUT, OP_NEWLINE:
                        begin
                            if (!wrap)
                            begin
                                // plain put at the cursor
                                ram_we    = 1'b1;
                                ram_waddr = base_reg + ADDR_W'(col_reg);
                                ram_wdata = {attr, pop_cmd.code};
                                col_next  = col_reg + 1'b1;
                                res_fire  = 1'b1;
                            end
                            else if (row_reg == BOTTOM_ROW)
                            begin
                                col_next       = '0;
                                scroll_next    = 1'b1;
                                pend_char_next = (pop_cmd.op == OP_PUT);
                                ptr_next       = '0;
                                state_next     = S_COPY;
                            end
                            else
                            begin
                                col_next  = '0;
                                row_next  = row_reg + 1'b1;
                                base_next = base_reg + COLS_A;
                                if (pop_cmd.op == OP_PUT)
                                begin
                                    state_next = S_WRITE;
                                end
                                else
                                begin
                                    res_fire = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            res_fire = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_fire     = 1'b1;
                res_scrolled = 1'b0;
                res_char     = ram_rdata[CHAR_W-1:0];
                res_attr     = ram_rdata[CELL_W-1:CHAR_W];
                state_next   = S_IDLE;
            end
            S_COPY:
            begin
                // read one row below, write the previous read one row up in the next cycle
                ram_we       = wr_pend_reg;
                wr_pend_next = 1'b1;
                wr_addr_next = ptr_reg;
                if (ptr_reg == LAST_COPY)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                ram_we     = wr_pend_reg;
                ptr_next   = LAST_ROW_BASE;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = {attr, BLANK_CODE};
                if (ptr_reg == LAST_CELL)
                begin
                    if (pend_char_reg)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        res_fire   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = base_reg + ADDR_W'(col_reg);
                ram_wdata  = {attr, char_reg};
                col_next   = col_reg + 1'b1;
                res_fire   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = res_fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            ptr_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            scroll_reg    <= 1'b0;
            pend_char_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            ptr_reg       <= ptr_next;
            wr_pend_reg   <= wr_pend_next;
            scroll_reg    <= scroll_next;
            pend_char_reg <= pend_char_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        char_reg    <= char_next;
        if (res_fire)
        begin
            read_char_reg  <= res_char;
            read_attr_reg  <= res_attr;
            cursor_row_reg <= ROW_OUT_W'(row_next);
            cursor_col_reg <= COL_OUT_W'(col_next);
            scrolled_reg   <= res_scrolled;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_char  = read_char_reg;
    assign read_attr  = read_attr_reg;
    assign cursor_row = cursor_row_reg;
    assign cursor_col = cursor_col_reg;
    assign scrolled   = scrolled_reg;

endmodule

`default_nettype wire

@@ rtl/text_console_writer_core.sv @@
// top level of the text console writer: front, command queue, back and colors
//
// Character-cell text console over a ROWS x COLUMNS screen store of char and
// attribute pairs (16 bits a cell, char in the low byte). The front takes an
// item whenever the command queue has room and sorts it into put, newline,
// clear, read or ignored; the back carries out one command at a time against
// a single-write, single-read store with registered read and sends exactly
// one result item per input item through an output register.
// Steps per item at the back, after the registered command queue:
//   - put without wrap, ignored kind, out-of-range read: done in the idle state
//   - read of a cell: store read issued in idle, data taken in the read state
//   - put or newline that wraps without scrolling: newline done in idle, put written in the write state
//   - clear screen: every cell blanked, one store write a cycle
//   - scroll: the copy moves one cell a cycle, a drain step follows, and the
//     bottom row is then blanked one cell a cycle, plus a write state when a
//     character follows the wrap
// The single write port of the screen store sets the length of clear and
// scroll. While the back works, the queue keeps taking items until it fills.
// The attribute written is {bg_color, fg_color}, taken from the config port;
// write colors only when no item is in flight.
`default_nettype none

module text_console_writer_core #(
    parameter int COLUMNS     = tcw_pkg::COLUMNS_DEF,     // 8 .. 127
    parameter int ROWS        = tcw_pkg::ROWS_DEF,        // 2 .. 32
    parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH_DEF  // 2 and up
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // config write port
    input  wire logic                            cfg_write,
    input  wire logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tcw_pkg::COLOR_W-1:0]     cfg_data,
    // input items
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [tcw_pkg::KIND_W-1:0]      kind,
    input  wire logic [tcw_pkg::CHAR_W-1:0]      char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0]     cell_index,
    // result items
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [tcw_pkg::CHAR_W-1:0]      read_char,
    output logic      [tcw_pkg::CHAR_W-1:0]      read_attr,
    output logic      [tcw_pkg::ROW_OUT_W-1:0]   cursor_row,
    output logic      [tcw_pkg::COL_OUT_W-1:0]   cursor_col,
    output logic                                 scrolled
);
    import tcw_pkg::*;

    // color registers
    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;
    logic [CHAR_W-1:0]  attr;

    // front to queue
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;

    // queue to back
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    // register writes; only two indexes exist
    always_comb
    begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FG:  fg_next = cfg_data;
                CFG_BG:  bg_next = cfg_data;
                default: fg_next = fg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= 4'd15;
            bg_reg <= 4'd0;
        end
        else
        begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;
        end
    end

    // background in the high nibble, foreground in the low nibble
    assign attr = {bg_reg, fg_reg};

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .char_code  (char_code),
        .cell_index (cell_index),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    tcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .attr       (attr),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_char  (read_char),
        .read_attr  (read_attr),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .scrolled   (scrolled)
    );

endmodule

`default_nettype wire

@@ rtl/tcw_checker.sv @@
// port-level checks of the text console writer and their binding
`default_nettype none

module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [tcw_pkg::CHAR_W-1:0]    read_char,
    input wire logic [tcw_pkg::CHAR_W-1:0]    read_attr,
    input wire logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row,
    input wire logic [tcw_pkg::COL_OUT_W-1:0] cursor_col,
    input wire logic                          scrolled
);
    import tcw_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_char) && $stable(read_attr)
            && $stable(cursor_row) && $stable(cursor_col) && $stable(scrolled))
        else $error("result changed while stalled");

    // a scroll leaves the cursor on the bottom row at column 0 or 1
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |->
            cursor_row == ROW_OUT_W'(ROWS - 1) && (cursor_col == 7'd0 || cursor_col == 7'd1))
        else $error("cursor misplaced after scroll");

    // column never passes the full-row mark
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(cursor_col) <= COLUMNS)
        else $error("cursor column out of range");

    // only a read returns cell data, and a read never scrolls
    a_read_no_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_char != 8'd0 || read_attr != 8'd0) |-> !scrolled)
        else $error("cell data on a scrolling item");

endmodule

bind text_console_writer_core tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);

`default_nettype wire

@@ tb/sv/tcw_console_checker.sv @@
`timescale 1ns / 100ps
// result checker of the text console writer: watches both channels, predicts and compares
module tcw_console_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tcw_pkg::COLOR_W-1:0]     cfg_data,
    input  wire logic                            in_valid,
    input  wire logic                            in_ready,
    input  wire logic [tcw_pkg::KIND_W-1:0]      kind,
    input  wire logic [tcw_pkg::CHAR_W-1:0]      char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0]     cell_index,
    input  wire logic                            out_valid,
    input  wire logic                            out_ready,
    input  wire logic [tcw_pkg::CHAR_W-1:0]      read_char,
    input  wire logic [tcw_pkg::CHAR_W-1:0]      read_attr,
    input  wire logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row,
    input  wire logic [tcw_pkg::COL_OUT_W-1:0]   cursor_col,
    input  wire logic                            scrolled,
    output int                                   pending,
    output int                                   errors,
    output int                                   results_seen,
    output int                                   scrolls_seen
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    typedef struct packed {
        logic [CHAR_W-1:0]    ch;
        logic [CHAR_W-1:0]    attr;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic                 scroll;
    } console_view_t;

    logic [CELL_W-1:0] screen_cells [CELLS];
    int                cursor_r;
    int                cursor_c;
    logic [COLOR_W-1:0] fg_now;
    logic [COLOR_W-1:0] bg_now;
    console_view_t     awaited_views [$];
    int                mismatch_total;
    int                result_total;
    int                scroll_total;

    assign errors       = mismatch_total;
    assign results_seen = result_total;
    assign scrolls_seen = scroll_total;

    function automatic logic [CELL_W-1:0] blank_cell();
        return {bg_now, fg_now, BLANK_CODE};
    endfunction

    // cursor to column 0 of the next row, or scroll on the bottom row
    function automatic logic next_line();
        cursor_c = 0;
        if (cursor_r + 1 < ROWS) begin
            cursor_r++;
            return 1'b0;
        end
        for (int i = 0; i + COLUMNS < CELLS; i++)
            screen_cells[i] = screen_cells[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen_cells[i] = blank_cell();
        return 1'b1;
    endfunction

    function automatic console_view_t run_console_item(
        input logic [KIND_W-1:0]  k,
        input logic [CHAR_W-1:0]  code,
        input logic [INDEX_W-1:0] idx
    );
        console_view_t v;
        v = '0;
        case (k)
            KIND_PUT:
            begin
                if (code == NEWLINE_CODE) begin
                    v.scroll = next_line();
                end else begin
                    if (cursor_c >= COLUMNS)
                        v.scroll = next_line();
                    screen_cells[cursor_r * COLUMNS + cursor_c] = {bg_now, fg_now, code};
                    cursor_c++;
                end
            end
            KIND_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_cells[i] = blank_cell();
            end
            KIND_READ:
            begin
                if (idx < CELLS)
                    {v.attr, v.ch} = screen_cells[idx];
            end
            default:
            begin
            end
        endcase
        v.row = cursor_r[ROW_OUT_W-1:0];
        v.col = cursor_c[COL_OUT_W-1:0];
        return v;
    endfunction

    task automatic check_field(
        input string       name,
        input logic [15:0] want,
        input logic [15:0] got,
        inout bit          bad
    );
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            bad = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        console_view_t want;
        bit            bad;
        if (!rst_n) begin
            cursor_r = 0;
            cursor_c = 0;
            fg_now   = FG_RESET;
            bg_now   = BG_RESET;
            awaited_views.delete();
            pending <= 0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_FG: fg_now = cfg_data;
                    CFG_BG: bg_now = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
                awaited_views.push_back(run_console_item(kind, char_code, cell_index));
            if (out_valid && out_ready) begin
                if (awaited_views.size() == 0) begin
                    $display({"%0t ns: result item with none expected, expected nothing, ",
                              "actual row %0d col %0d"},
                             $time, cursor_row, cursor_col);
                    mismatch_total++;
                end else begin
                    want = awaited_views.pop_front();
                    bad  = 1'b0;
                    check_field("read_char", 16'(want.ch), 16'(read_char), bad);
                    check_field("read_attr", 16'(want.attr), 16'(read_attr), bad);
                    check_field("cursor_row", 16'(want.row), 16'(cursor_row), bad);
                    check_field("cursor_col", 16'(want.col), 16'(cursor_col), bad);
                    check_field("scrolled", 16'(want.scroll), 16'(scrolled), bad);
                    if (bad)
                        mismatch_total++;
                    result_total++;
                    if (want.scroll)
                        scroll_total++;
                end
            end
            pending <= awaited_views.size();
        end
    end

endmodule

@@ tb/sv/tb_text_console_writer_core.sv @@
`timescale 1ns / 100ps
// testbench top: directed and random console items against the text console writer, with verdict
module tb_text_console_writer_core;
    import tcw_pkg::*;

    // screen geometry, the block's defaults
    localparam int SCREEN_COLS  = COLUMNS_DEF;
    localparam int SCREEN_ROWS  = ROWS_DEF;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

    // kind code the block ignores
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

    // run shape: counted items (ignored kinds excluded), color phases, quiet tail
    localparam int TOTAL_ITEMS = 1070;
    localparam int PHASE_COUNT = 6;
    localparam int CALM_TAIL   = 120;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]     cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [KIND_W-1:0]      kind;
    logic [CHAR_W-1:0]      char_code;
    logic [INDEX_W-1:0]     cell_index;
    logic                   out_valid;
    logic                   out_ready;
    logic [CHAR_W-1:0]      read_char;
    logic [CHAR_W-1:0]      read_attr;
    logic [ROW_OUT_W-1:0]   cursor_row;
    logic [COL_OUT_W-1:0]   cursor_col;
    logic                   scrolled;

    int pending;
    int errors;
    int results_seen;
    int scrolls_seen;

    // no idling on either side once this is set
    bit calm;

    // what was sent
    int items_sent;
    int chars_sent;
    int newlines_sent;
    int clears_sent;
    int reads_sent;
    int ignored_sent;
    int color_settings;

    text_console_writer_core #(
        .COLUMNS (SCREEN_COLS),
        .ROWS    (SCREEN_ROWS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_char  (read_char),
        .read_attr  (read_attr),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .scrolled   (scrolled)
    );

    tcw_console_checker #(
        .COLUMNS (SCREEN_COLS),
        .ROWS    (SCREEN_ROWS)
    ) console_watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .char_code    (char_code),
        .cell_index   (cell_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_char    (read_char),
        .read_attr    (read_attr),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col),
        .scrolled     (scrolled),
        .pending      (pending),
        .errors       (errors),
        .results_seen (results_seen),
        .scrolls_seen (scrolls_seen)
    );

    always #4 clk = ~clk;

    // one item through the input channel; valid stays up until the handshake,
    // then maybe a burst of idle cycles with valid low
    task automatic send_item(
        input logic [KIND_W-1:0]  k,
        input logic [CHAR_W-1:0]  code,
        input logic [INDEX_W-1:0] idx
    );
        in_valid   <= 1'b1;
        kind       <= k;
        char_code  <= code;
        cell_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (k)
            KIND_PUT:
            begin
                if (code == NEWLINE_CODE)
                    newlines_sent++;
                else
                    chars_sent++;
            end
            KIND_CLEAR: clears_sent++;
            KIND_READ:  reads_sent++;
            default:    ignored_sent++;
        endcase
        if (k != KIND_UNUSED)
            items_sent++;
        if (items_sent >= TOTAL_ITEMS - CALM_TAIL)
            calm = 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13))
                @(posedge clk);
        end
    endtask

    // a run of printable-or-not bytes, never the newline byte
    task automatic send_text(input int count);
        logic [CHAR_W-1:0] code;
        repeat (count)
        begin
            do
                code = CHAR_W'($urandom_range(0, 255));
            while (code == NEWLINE_CODE);
            send_item(KIND_PUT, code, INDEX_W'($urandom_range(0, INDEX_MAX)));
        end
    endtask

    // every item answered: every result item has been through the checker
    task automatic wait_idle();
        if (in_valid)
            in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        cfg_write <= 1'b1;
        cfg_index <= CFG_FG;
        cfg_data  <= fg;
        @(posedge clk);
        cfg_index <= CFG_BG;
        cfg_data  <= bg;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        color_settings++;
    endtask

    // result side: random stall bursts, none in the quiet tail
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13))
                    @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24))
                @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        int phase_end;
        int pick;
        int phase;

        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_index  <= CFG_FG;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        kind       <= KIND_PUT;
        char_code  <= '0;
        cell_index <= '0;
        calm           = 1'b0;
        items_sent     = 0;
        chars_sent     = 0;
        newlines_sent  = 0;
        clears_sent    = 0;
        reads_sent     = 0;
        ignored_sent   = 0;
        color_settings = 1;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset colors; only cells already written are read
        send_item(KIND_PUT, 8'h00, '0);                         // lowest byte, cell 0
        send_item(KIND_PUT, 8'hFF, INDEX_MAX);                  // highest byte, cell 1
        send_item(KIND_READ, 8'hFF, INDEX_W'(0));
        send_item(KIND_READ, 8'h00, INDEX_W'(1));
        send_item(KIND_READ, 8'h00, INDEX_MAX);                 // out of range, all index bits
        send_item(KIND_READ, 8'h00, INDEX_W'(SCREEN_CELLS));    // first index past the screen
        send_item(KIND_UNUSED, 8'hFF, INDEX_MAX);               // ignored kind keeps the cursor
        send_item(KIND_PUT, NEWLINE_CODE, '0);                  // newline is never stored
        send_item(KIND_PUT, 8'h55, '0);
        send_item(KIND_READ, 8'h00, INDEX_W'(SCREEN_COLS));
        send_item(KIND_CLEAR, 8'hFF, INDEX_MAX);                // whole screen blank, cursor kept
        send_item(KIND_READ, 8'h00, INDEX_W'(0));
        send_item(KIND_READ, 8'h00, INDEX_W'(SCREEN_CELLS - 1));
        send_item(KIND_PUT, 8'hAA, '0);
        send_item(KIND_PUT, NEWLINE_CODE, INDEX_MAX);
        send_item(KIND_READ, 8'h00, INDEX_W'(SCREEN_COLS + 1));
        send_item(KIND_UNUSED, 8'h00, '0);
        send_item(KIND_READ, 8'h00, INDEX_W'(SCREEN_CELLS + 46));

        // random part: one color setting a phase, extremes first;
        // the screen is fully written from here on, so any index may be read
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_idle();
            case (phase)
                0:       set_colors(4'd0, 4'd15);
                1:       set_colors(4'd15, 4'd15);
                2:       set_colors(4'd0, 4'd0);
                3:       set_colors(4'd15, 4'd0);
                default: set_colors(COLOR_W'($urandom_range(0, 15)),
                                    COLOR_W'($urandom_range(0, 15)));
            endcase
            phase_end = (phase + 1) * TOTAL_ITEMS / PHASE_COUNT;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    // short line ended by newline; scrolls once at the bottom
                    send_text($urandom_range(0, 12));
                    send_item(KIND_PUT, NEWLINE_CODE, INDEX_W'($urandom_range(0, INDEX_MAX)));
                end else if (pick < 45) begin
                    // long line: close to a row of text, wrapping on the put after the row fills
                    send_text($urandom_range(SCREEN_COLS - 4, SCREEN_COLS + 6));
                end else if (pick < 65) begin
                    // reads, biased to the rows that scrolls move and blank
                    repeat ($urandom_range(1, 6))
                    begin
                        case ($urandom_range(0, 9))
                            0:
                                send_item(KIND_READ, CHAR_W'($urandom_range(0, 255)),
                                          INDEX_W'($urandom_range(SCREEN_CELLS, INDEX_MAX)));
                            1, 2, 3:
                                send_item(KIND_READ, CHAR_W'($urandom_range(0, 255)),
                                          INDEX_W'($urandom_range(
                                              SCREEN_CELLS - 2 * SCREEN_COLS,
                                              SCREEN_CELLS - 1)));
                            default:
                                send_item(KIND_READ, CHAR_W'($urandom_range(0, 255)),
                                          INDEX_W'($urandom_range(0, SCREEN_CELLS - 1)));
                        endcase
                    end
                end else if (pick < 70) begin
                    send_item(KIND_CLEAR, CHAR_W'($urandom_range(0, 255)),
                              INDEX_W'($urandom_range(0, INDEX_MAX)));
                end else if (pick < 80) begin
                    // newline bursts: back-to-back scrolls once on the bottom row
                    repeat ($urandom_range(1, 4))
                        send_item(KIND_PUT, NEWLINE_CODE,
                                  INDEX_W'($urandom_range(0, INDEX_MAX)));
                end else if (pick < 90) begin
                    // noise: any kind, any fields
                    repeat ($urandom_range(1, 3))
                        send_item(KIND_W'($urandom_range(0, 3)),
                                  CHAR_W'($urandom_range(0, 255)),
                                  INDEX_W'($urandom_range(0, INDEX_MAX)));
                end else begin
                    // text within a line, no newline
                    send_text($urandom_range(1, 20));
                end
            end
        end

        // all items in: wait for every result, then a short quiet stretch
        wait_idle();
        repeat (20)
            @(posedge clk);

        $display("sent %0d characters, %0d newlines, %0d clears, %0d reads, %0d ignored items",
                 chars_sent, newlines_sent, clears_sent, reads_sent, ignored_sent);
        $display("checked %0d results, %0d with a scroll, over %0d color settings",
                 results_seen, scrolls_seen, color_settings);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog: far beyond a run with every scroll and clear at full length
    initial
    begin
        #10_000_000;
        $display("timeout with %0d results still expected", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
